@@ hdl/bsp_pkg.sv @@
// Shared types and constants for the background subtraction pixel block.
// No dependencies; used by every other file in hdl/.
`default_nettype none
package bsp_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;
    localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam int OUT_DEPTH    = 2;
    localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);

    localparam logic [7:0] LUMA_R_W  = 8'd77;
    localparam logic [7:0] LUMA_G_W  = 8'd151;
    localparam logic [7:0] LUMA_B_W  = 8'd28;
    localparam logic [7:0] BLEND_OLD = 8'd247;
    localparam logic [7:0] BLEND_NEW = 8'd9;

    localparam logic [7:0] THRESHOLD_RESET = 8'd30;

    // classified pixel passed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              in_view;
        logic              capture;
        logic [7:0]        luma;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } mid_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       moving;
        logic [7:0] luma;
    } res_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage
`default_nettype wire

@@ hdl/bsp_front.sv @@
// Front end: accepts pixels, forms luma, store address and in-frame flag.
// Depends on bsp_pkg.
`default_nettype none
module bsp_front
(
    input  wire logic                  push,
    input  wire logic [8:0]            pix_x,
    input  wire logic [7:0]            pix_y,
    input  wire logic [7:0]            red_in,
    input  wire logic [7:0]            green_in,
    input  wire logic [7:0]            blue_in,
    input  wire logic                  capture,
    input  wire logic                  queue_full,
    input  wire bsp_pkg::back_status_t back_status,
    output logic                       full,
    output logic                       queue_push,
    output bsp_pkg::mid_t              queue_data
);

    logic [15:0] luma_sum;
    logic [31:0] addr_wide;
    logic        in_view;

    always_comb
    begin
        luma_sum = 16'(bsp_pkg::LUMA_R_W * 16'(red_in))
                 + 16'(bsp_pkg::LUMA_G_W * 16'(green_in))
                 + 16'(bsp_pkg::LUMA_B_W * 16'(blue_in));
        in_view  = (32'(pix_x) < 32'(bsp_pkg::FRAME_WIDTH))
                && (32'(pix_y) < 32'(bsp_pkg::FRAME_HEIGHT));
        addr_wide = 32'(pix_y) * 32'(bsp_pkg::FRAME_WIDTH) + 32'(pix_x);

        full       = queue_full || back_status.clearing;
        queue_push = push && !full;

        queue_data.addr    = in_view ? addr_wide[bsp_pkg::ADDR_W-1:0] : '0;
        queue_data.in_view = in_view;
        queue_data.capture = capture;
        queue_data.luma    = luma_sum[15:8];
        queue_data.red     = red_in;
        queue_data.green   = green_in;
        queue_data.blue    = blue_in;
    end

endmodule
`default_nettype wire

@@ hdl/bsp_queue.sv @@
// Short FIFO of classified pixels between front and back.
// Depends on bsp_pkg.
`default_nettype none
module bsp_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bsp_pkg::mid_t push_data,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output bsp_pkg::mid_t      head
);

    bsp_pkg::mid_t               entry_reg [bsp_pkg::QUEUE_DEPTH];
    logic [bsp_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bsp_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bsp_pkg::QPTR_W:0]    count_reg, count_next;
    logic                        do_push, do_pop;

    always_comb
    begin
        full        = (count_reg == (bsp_pkg::QPTR_W+1)'(bsp_pkg::QUEUE_DEPTH));
        empty       = (count_reg == '0);
        head        = entry_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (bsp_pkg::QPTR_W+1)'(do_push)
                                - (bsp_pkg::QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bsp_back.sv @@
// Back end: background store, clearing pass, compare, blend write-back and
// result buffer. Depends on bsp_pkg.
`default_nettype none
module bsp_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    threshold,
    input  wire logic          queue_empty,
    input  wire bsp_pkg::mid_t queue_head,
    output logic               queue_pop,
    output bsp_pkg::back_status_t status,
    input  wire logic          pop,
    output logic               empty,
    output bsp_pkg::res_t      result
);

    // background store
    logic [7:0]                 store_mem [bsp_pkg::STORE_DEPTH];
    logic [7:0]                 rd_data_reg;

    logic                       clearing_reg;
    logic [bsp_pkg::ADDR_W-1:0] clr_cnt_reg;

    // compare / write-back stage
    logic                       b_valid_reg;
    bsp_pkg::mid_t              b_item_reg;
    logic                       fwd_valid_reg;
    logic [bsp_pkg::ADDR_W-1:0] fwd_addr_reg;
    logic [7:0]                 fwd_data_reg;

    // result buffer
    bsp_pkg::res_t                 out_reg [bsp_pkg::OUT_DEPTH];
    logic [bsp_pkg::OUT_PTR_W-1:0] out_wr_reg, out_rd_reg;
    logic [bsp_pkg::OUT_PTR_W:0]   out_cnt_reg, out_cnt_next;
    logic                          out_full;

    logic [7:0]                 bg;
    logic [7:0]                 diff;
    logic                       moving;
    logic [15:0]                blend_sum;
    logic [7:0]                 new_bg;
    logic                       b_adv, b_free, a_go, do_pop;
    logic                       b_write;
    bsp_pkg::res_t              b_res;

    always_comb
    begin
        out_full = (out_cnt_reg == (bsp_pkg::OUT_PTR_W+1)'(bsp_pkg::OUT_DEPTH));
        empty    = (out_cnt_reg == '0);
        result   = out_reg[out_rd_reg];
        do_pop   = pop && !empty;

        b_adv     = b_valid_reg && !out_full;
        b_free    = !b_valid_reg || b_adv;
        a_go      = !queue_empty && b_free && !clearing_reg;
        queue_pop = a_go;
        b_write   = b_adv && b_item_reg.in_view;

        if (!b_item_reg.in_view)
        begin
            bg = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == b_item_reg.addr))
        begin
            bg = fwd_data_reg;
        end
        else
        begin
            bg = rd_data_reg;
        end

        diff      = (b_item_reg.luma > bg) ? b_item_reg.luma - bg : bg - b_item_reg.luma;
        moving    = diff > threshold;
        blend_sum = 16'(bsp_pkg::BLEND_OLD * 16'(bg))
                  + 16'(bsp_pkg::BLEND_NEW * 16'(b_item_reg.luma));
        new_bg    = b_item_reg.capture ? b_item_reg.luma : blend_sum[15:8];

        b_res.red    = moving ? b_item_reg.red   : '0;
        b_res.green  = moving ? b_item_reg.green : '0;
        b_res.blue   = moving ? b_item_reg.blue  : '0;
        b_res.moving = moving;
        b_res.luma   = b_item_reg.luma;

        out_cnt_next = out_cnt_reg + (bsp_pkg::OUT_PTR_W+1)'(b_adv)
                                   - (bsp_pkg::OUT_PTR_W+1)'(do_pop);

        status.clearing = clearing_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == bsp_pkg::ADDR_W'(bsp_pkg::STORE_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (a_go)
            begin
                b_valid_reg   <= 1'b1;
                fwd_valid_reg <= b_write;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            b_item_reg   <= queue_head;
            rd_data_reg  <= store_mem[queue_head.addr];
            fwd_addr_reg <= b_item_reg.addr;
            fwd_data_reg <= new_bg;
        end
        if (clearing_reg)
        begin
            store_mem[clr_cnt_reg] <= '0;
        end
        else if (b_write)
        begin
            store_mem[b_item_reg.addr] <= new_bg;
        end
        if (b_adv)
        begin
            out_reg[out_wr_reg] <= b_res;
        end
    end

endmodule
`default_nettype wire

@@ hdl/background_subtract_pixel.sv @@
// Top level of the background subtraction pixel block.
// Depends on bsp_pkg, bsp_front, bsp_queue and bsp_back.
`default_nettype none
// One pixel per clock in and one result per clock out while full is low and
// pop is held; a result passes the pixel queue, the compare stage register
// and the result buffer before it is on the result ports. Each in-frame
// pixel costs one read and one write of the background store, a memory with
// one read and one write port of FRAME_WIDTH*FRAME_HEIGHT bytes (76800
// bytes at 320x240). After reset a clearing pass zeroes the store, during
// which full stays high; threshold writes are taken throughout.
// Back-to-back pixels at the same coordinates are handled by forwarding.
module background_subtract_pixel
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [8:0] pix_x,
    input  wire logic [7:0] pix_y,
    input  wire logic [7:0] red_in,
    input  wire logic [7:0] green_in,
    input  wire logic [7:0] blue_in,
    input  wire logic       capture,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out,
    output logic            moving,
    output logic [7:0]      luma_out
);

    logic [7:0]            threshold_reg;
    logic                  q_push, q_pop, q_full, q_empty;
    bsp_pkg::mid_t         q_in, q_head;
    bsp_pkg::back_status_t back_status;
    bsp_pkg::res_t         res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= bsp_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    bsp_front u_front
    (
        .push        (push),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .capture     (capture),
        .queue_full  (q_full),
        .back_status (back_status),
        .full        (full),
        .queue_push  (q_push),
        .queue_data  (q_in)
    );

    bsp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    bsp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .threshold   (threshold_reg),
        .queue_empty (q_empty),
        .queue_head  (q_head),
        .queue_pop   (q_pop),
        .status      (back_status),
        .pop         (pop),
        .empty       (empty),
        .result      (res)
    );

    assign red_out   = res.red;
    assign green_out = res.green;
    assign blue_out  = res.blue;
    assign moving    = res.moving;
    assign luma_out  = res.luma;

    // no pixel transfer while the store is being cleared
    a_no_push_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !back_status.clearing)
        else $error("pixel transfer during clearing pass");

    // clearing pass runs once per reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !back_status.clearing |=> !back_status.clearing)
        else $error("clearing pass restarted");

    // a still pixel shows black
    a_still_black: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !moving) |-> (red_out == '0 && green_out == '0 && blue_out == '0))
        else $error("colour passed on a still pixel");

    // nothing reaches the back end before the store is clear
    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> (empty && q_empty))
        else $error("item in flight during clearing pass");

endmodule
`default_nettype wire
